// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tokenizer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AET_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AET_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/aet_pkg.sv =====
// ----------------------------------------------------------------------------
// Tokenizer package
// Shared types, character codes and the divide-by-ten constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aet_pkg;

  localparam int MAX_TOKEN_LEN = 12;
  localparam int MANT_W        = 37;
  localparam int FRAC_BITS     = 16;
  localparam int VALUE_W       = MANT_W + FRAC_BITS;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam int DIV_W         = 64;
  localparam int CHUNK_W       = 16;
  localparam int PART_W        = CHUNK_W + 4;
  localparam int RECIP_W       = 21;
  localparam int RECIP_SHIFT   = 24;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 21'h19999A;
  localparam logic [1:0]         STEP_LAST = 2'(DIV_W / CHUNK_W - 1);

  localparam logic [3:0] LEN_LIMIT = 4'(MAX_TOKEN_LEN - 1);
  localparam logic [3:0] FRAC_MAX  = 4'd11;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_INT  = 2'd1,
    PH_DOT  = 2'd2,
    PH_FRAC = 2'd3
  } aet_phase_e;

  typedef enum logic [3:0] {
    KIND_NUMBER   = 4'd0,
    KIND_ADD      = 4'd1,
    KIND_SUB      = 4'd2,
    KIND_MUL      = 4'd3,
    KIND_DIV      = 4'd4,
    KIND_LPAREN   = 4'd5,
    KIND_RPAREN   = 4'd6,
    KIND_EOL      = 4'd7,
    KIND_SYNTAX   = 4'd8,
    KIND_TOO_LONG = 4'd9
  } aet_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_OUT  = 2'd2
  } aet_bstate_e;

  typedef struct packed {
    logic              num_valid;
    logic [MANT_W-1:0] mant;
    logic [3:0]        frac;
    logic              tok_valid;
    aet_kind_e         kind;
  } aet_entry_t;

endpackage

// ===== rtl/aet_front.sv =====
// ----------------------------------------------------------------------------
// Tokenizer front end
// Classifies one character per beat, tracks the pending number and writes
// the number, operator, end-of-line and error tokens it causes into the token queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aet_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         ch_i,
  output logic               wr_en_o,
  output aet_pkg::aet_entry_t wr_data_o
);
  import aet_pkg::*;

  aet_phase_e        phase_q, phase_d;
  logic [MANT_W-1:0] mant_q, mant_d;
  logic [3:0]        frac_q, frac_d;
  logic [3:0]        len_q, len_d;

  logic is_digit, is_dot, close;
  aet_entry_t ent;

  assign is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign is_dot   = (ch_i == CH_DOT);
  assign close    = (phase_q != PH_IDLE) && !is_digit && !is_dot;

  always_comb begin
    ent           = '0;
    ent.num_valid = close;
    ent.mant      = mant_q;
    ent.frac      = frac_q;
    ent.kind      = KIND_NUMBER;
    phase_d       = phase_q;
    mant_d        = mant_q;
    frac_d        = frac_q;
    len_d         = len_q;
    if (close) begin
      phase_d = PH_IDLE;
      mant_d  = '0;
      frac_d  = '0;
      len_d   = '0;
    end
    case (ch_i)
      CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: ;
      CH_NL:    begin ent.tok_valid = 1'b1; ent.kind = KIND_EOL;    end
      CH_PLUS:  begin ent.tok_valid = 1'b1; ent.kind = KIND_ADD;    end
      CH_MINUS: begin ent.tok_valid = 1'b1; ent.kind = KIND_SUB;    end
      CH_STAR:  begin ent.tok_valid = 1'b1; ent.kind = KIND_MUL;    end
      CH_SLASH: begin ent.tok_valid = 1'b1; ent.kind = KIND_DIV;    end
      CH_LPAR:  begin ent.tok_valid = 1'b1; ent.kind = KIND_LPAREN; end
      CH_RPAR:  begin ent.tok_valid = 1'b1; ent.kind = KIND_RPAREN; end
      default: begin
        if (is_digit || is_dot) begin
          if (len_q >= LEN_LIMIT) begin
            ent.tok_valid = 1'b1;
            ent.kind      = KIND_TOO_LONG;
            phase_d       = PH_IDLE;
            mant_d        = '0;
            frac_d        = '0;
            len_d         = '0;
          end else if (is_digit) begin
            mant_d = (mant_q << 3) + (mant_q << 1) + MANT_W'(ch_i - CH_ZERO);
            if (phase_q == PH_DOT || phase_q == PH_FRAC) begin
              phase_d = PH_FRAC;
              frac_d  = frac_q + 4'd1;
            end else begin
              phase_d = PH_INT;
            end
            len_d = len_q + 4'd1;
          end else if (phase_q == PH_INT) begin
            phase_d = PH_DOT;
            len_d   = len_q + 4'd1;
          end else begin
            ent.tok_valid = 1'b1;
            ent.kind      = KIND_SYNTAX;
            phase_d       = PH_IDLE;
            mant_d        = '0;
            frac_d        = '0;
            len_d         = '0;
          end
        end
      end
    endcase
  end

  assign wr_en_o   = accept_i && (ent.num_valid || ent.tok_valid);
  assign wr_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      mant_q  <= '0;
      frac_q  <= '0;
      len_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      mant_q  <= mant_d;
      frac_q  <= frac_d;
      len_q   <= len_d;
    end
  end

endmodule

// ===== rtl/aet_queue.sv =====
// ----------------------------------------------------------------------------
// Token queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aet_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  aet_pkg::aet_entry_t wr_data_i,
  input  logic                rd_en_i,
  output aet_pkg::aet_entry_t rd_data_o,
  output logic                full_o,
  output logic                empty_o
);
  import aet_pkg::*;

  aet_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_wr, do_rd;

  assign full_o    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_rd) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (do_wr && !do_rd) begin
        count_q <= count_q + (QPTR_W + 1)'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== rtl/aet_back.sv =====
// ----------------------------------------------------------------------------
// Tokenizer back end
// Takes queued tokens, scales numbers by a power of ten through repeated
// division by ten in 16-bit steps and holds each result beat in an output
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aet_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  aet_pkg::aet_entry_t q_data_i,
  output logic                q_rd_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [3:0]          token_kind_o,
  output logic [52:0]         value_o,
  output logic                last_o
);
  import aet_pkg::*;

  aet_bstate_e state_q, state_d;

  logic               tok_pend_q, tok_pend_d;
  aet_kind_e          tok_kind_q, tok_kind_d;
  logic [DIV_W-1:0]   dv_q, dv_d;
  logic [3:0]         rem_q, rem_d;
  logic [1:0]         step_q, step_d;
  logic [3:0]         dig_q, dig_d;
  aet_kind_e          kind_q, kind_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic               last_q, last_d;

  logic [PART_W-1:0]         part;
  logic [PART_W+RECIP_W-1:0] prod;
  logic [CHUNK_W-1:0]        qchunk;
  logic [PART_W-1:0]         qwide;
  logic [PART_W-1:0]         tenq;
  logic [PART_W-1:0]         diff;
  logic [DIV_W-1:0]          dv_next;
  logic [3:0]                fclamp;

  assign part    = {rem_q, dv_q[DIV_W-1 -: CHUNK_W]};
  assign prod    = {{RECIP_W{1'b0}}, part} * {{PART_W{1'b0}}, RECIP_TEN};
  assign qchunk  = prod[RECIP_SHIFT +: CHUNK_W];
  assign qwide   = {{(PART_W - CHUNK_W){1'b0}}, qchunk};
  assign tenq    = (qwide << 3) + (qwide << 1);
  assign diff    = part - tenq;
  assign dv_next = {dv_q[DIV_W-CHUNK_W-1:0], qchunk};
  assign fclamp  = (q_data_i.frac > FRAC_MAX) ? FRAC_MAX : q_data_i.frac;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          if (q_data_i.num_valid && (fclamp != '0)) state_d = BK_DIV;
          else state_d = BK_OUT;
        end
      end
      BK_DIV: begin
        if ((step_q == STEP_LAST) && (dig_q == 4'd1)) state_d = BK_OUT;
      end
      BK_OUT: begin
        if (pop_i && !tok_pend_q) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_rd_o     = 1'b0;
    tok_pend_d = tok_pend_q;
    tok_kind_d = tok_kind_q;
    dv_d       = dv_q;
    rem_d      = rem_q;
    step_d     = step_q;
    dig_d      = dig_q;
    kind_d     = kind_q;
    value_d    = value_q;
    last_d     = last_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_rd_o     = 1'b1;
          tok_kind_d = q_data_i.kind;
          if (q_data_i.num_valid) begin
            tok_pend_d = q_data_i.tok_valid;
            dv_d       = DIV_W'({q_data_i.mant, FRAC_BITS'(0)});
            rem_d      = '0;
            step_d     = '0;
            dig_d      = fclamp;
            kind_d     = KIND_NUMBER;
            value_d    = {q_data_i.mant, FRAC_BITS'(0)};
            last_d     = !q_data_i.tok_valid;
          end else begin
            tok_pend_d = 1'b0;
            kind_d     = q_data_i.kind;
            value_d    = '0;
            last_d     = 1'b1;
          end
        end
      end
      BK_DIV: begin
        dv_d   = dv_next;
        step_d = step_q + 2'd1;
        if (step_q == STEP_LAST) begin
          rem_d = '0;
          dig_d = dig_q - 4'd1;
          if (dig_q == 4'd1) begin
            kind_d  = KIND_NUMBER;
            value_d = dv_next[VALUE_W-1:0];
            last_d  = !tok_pend_q;
          end
        end else begin
          rem_d = diff[3:0];
        end
      end
      BK_OUT: begin
        if (pop_i && tok_pend_q) begin
          tok_pend_d = 1'b0;
          kind_d     = tok_kind_q;
          value_d    = '0;
          last_d     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      tok_pend_q <= 1'b0;
      tok_kind_q <= KIND_NUMBER;
      dv_q       <= '0;
      rem_q      <= '0;
      step_q     <= '0;
      dig_q      <= '0;
      kind_q     <= KIND_NUMBER;
      value_q    <= '0;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      tok_pend_q <= tok_pend_d;
      tok_kind_q <= tok_kind_d;
      dv_q       <= dv_d;
      rem_q      <= rem_d;
      step_q     <= step_d;
      dig_q      <= dig_d;
      kind_q     <= kind_d;
      value_q    <= value_d;
      last_q     <= last_d;
    end
  end

  assign empty_o      = (state_q != BK_OUT);
  assign token_kind_o = kind_q;
  assign value_o      = value_q;
  assign last_o       = last_q;

endmodule

// ===== rtl/arith_expression_tokenizer_core.sv =====
// A character is classified in its accept cycle; its first token passes through
// the token queue and the back end output registers, and a number with fraction
// digits also through the division steps, 16 bits per step. Throughput: one
// character per cycle while the four-entry token queue has room; the back end takes
// one queued token at a time and shows a second token of a character after its number.
// Reset clears the number state, the queue and the output registers at once.
// ----------------------------------------------------------------------------
// Arithmetic expression tokenizer core
// Character-in, token-out lexer with a decoupled front end and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arith_expression_tokenizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  token_kind_o,
  output logic [52:0] value_o,
  output logic        last_o
);
  import aet_pkg::*;

  aet_entry_t wr_data, rd_data;
  logic       wr_en, rd_en, q_empty, accept;

  assign accept = push && !full;

  aet_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .ch_i      (ch_i),
    .wr_en_o   (wr_en),
    .wr_data_o (wr_data)
  );

  aet_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_data_o (rd_data),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  aet_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (rd_data),
    .q_rd_o       (rd_en),
    .pop_i        (pop),
    .empty_o      (empty),
    .token_kind_o (token_kind_o),
    .value_o      (value_o),
    .last_o       (last_o)
  );

endmodule

// ===== rtl/aet_checker.sv =====
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Watches the result side of the top level for ordering and value rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aet_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [3:0]  token_kind_i,
  input logic [52:0] value_i,
  input logic        last_i
);
  import aet_pkg::*;

  `AET_ASSERT_IMP(a_value_zero, clk_i, rst_ni, !empty && (token_kind_i != KIND_NUMBER), value_i == '0)
  `AET_ASSERT_IMP(a_notlast_num, clk_i, rst_ni, !empty && !last_i, token_kind_i == KIND_NUMBER)
  `AET_ASSERT_NXT(a_pair_follow, clk_i, rst_ni, pop && !empty && !last_i, !empty && last_i)
  `AET_ASSERT_NXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(token_kind_i))

endmodule

bind arith_expression_tokenizer_core aet_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .token_kind_i (token_kind_o),
  .value_i      (value_o),
  .last_i       (last_o)
);
